// ===== rtl/ppid_pkg.sv =====
// Shared types and constants for the positional PID controller.
// Used by ppid_mul, ppid_div and positional_pid_controller_top; depends on nothing.
package ppid_pkg;

   // Default saturation width of error and drive
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int FIELD_W      = 32;   // target, measured, error_value, drive
   localparam int DT_W         = 32;   // time_step
   localparam int INTEG_W      = 48;   // integral and derivative, signed whole numbers (Q48.0)
   localparam int TIME_FRAC_W  = 24;   // time step is in units of 2^-24 s
   localparam int GAIN_FRAC_W  = 16;   // gains have 16 fraction bits: Q6.16, Q5.16, Q4.16

   // Gain registers
   localparam int PROP_W       = 22;
   localparam int INTEG_GAIN_W = 21;
   localparam int DERIV_GAIN_W = 20;
   localparam int CSR_DATA_W   = 22;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN = 2'd2;

   localparam logic [PROP_W-1:0]       PROP_MIN    = 22'd655;
   localparam logic [PROP_W-1:0]       PROP_MAX    = 22'd3276800;
   localparam logic [PROP_W-1:0]       PROP_RESET  = 22'd65536;
   localparam logic [INTEG_GAIN_W-1:0] INTEG_MAX   = 21'd1310720;
   localparam logic [INTEG_GAIN_W-1:0] INTEG_RESET = 21'd6554;
   localparam logic [DERIV_GAIN_W-1:0] DERIV_MAX   = 20'd655360;
   localparam logic [DERIV_GAIN_W-1:0] DERIV_RESET = 20'd3277;

   // Smallest time step, in 2^-24 s units, above 1 us
   localparam logic [DT_W-1:0] DT_MIN_UNITS = 32'd17;

   // Status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ===== rtl/ppid_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
// Depends on ppid_pkg for the unit status struct.
module ppid_mul #(
   parameter int XW = 48,
   parameter int MW = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [XW-1:0]      x,
   input  logic        [MW-1:0]      m,
   output ppid_pkg::unit_stat_type   stat,
   output logic signed [XW+MW-1:0]   prod
);

   localparam int PW = XW + MW;
   localparam int CW = $clog2(MW + 1);
   localparam logic [CW-1:0] CNT_LOAD = CW'(MW);
   localparam logic [CW-1:0] CNT_LAST = CW'(1);

   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] xs_ff, xs_in;
   logic [MW-1:0]        m_ff, m_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // Take one multiplier bit per cycle, least significant first
   always_comb begin
      acc_in  = acc_ff;
      xs_in   = xs_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         xs_in   = PW'(x);
         m_in    = m;
         cnt_in  = CNT_LOAD;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (m_ff[0]) begin
            acc_in = acc_ff + xs_ff;
         end
         xs_in  = xs_ff <<< 1;
         m_in   = m_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      xs_ff  <= xs_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;

endmodule

// ===== rtl/ppid_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ppid_pkg for the unit status struct.
module ppid_div #(
   parameter int NW = 57,
   parameter int MW = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NW-1:0]           num,
   input  logic [MW-1:0]           den,
   output ppid_pkg::unit_stat_type stat,
   output logic [NW-1:0]           quo
);

   localparam int CW = $clog2(NW + 1);
   localparam logic [CW-1:0] CNT_LOAD = CW'(NW);
   localparam logic [CW-1:0] CNT_LAST = CW'(1);

   logic [MW:0]   rem_ff, rem_in;
   logic [NW-1:0] q_ff, q_in;
   logic [MW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [MW:0]   rem_sh;
   logic          fits;

   // Bring down the next numerator bit and trial-subtract the divisor
   always_comb begin
      rem_sh  = {rem_ff[MW-1:0], q_ff[NW-1]};
      fits    = (rem_sh >= {1'b0, den_ff});
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
         cnt_in  = CNT_LOAD;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         q_in   = {q_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = q_ff;

endmodule

// ===== rtl/positional_pid_controller_top.sv =====
// Positional PID controller: sequencer, gain registers and result register.
// Depends on ppid_pkg, ppid_mul (shared serial multiplier) and ppid_div.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-----------------
//   req     | req_target, req_measured, req_time_step| req_valid/ready
//   rsp     | rsp_error_value, rsp_drive             | rsp_valid/ready
//   csr     | csr_index, csr_wdata                   | csr_we, no wait
//
// One word is worked on at a time. The shared multiplier forms four products in
// turn, one multiplier bit per cycle, and the divider gives one quotient bit per
// cycle; no division runs when the time step is below 17 units, and the
// derivative is then zero. Reset is synchronous: gains to defaults, integral and
// last error to zero, sequencer idle, result register empty. A finished word
// waits in the result register while rsp stalls; the sequencer holds in its
// last state until that register is free.
module positional_pid_controller_top #(
   parameter int VALUE_WIDTH = ppid_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ppid_pkg::FIELD_W-1:0]   req_target,
   input  logic signed [ppid_pkg::FIELD_W-1:0]   req_measured,
   input  logic        [ppid_pkg::DT_W-1:0]      req_time_step,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [ppid_pkg::FIELD_W-1:0]   rsp_error_value,
   output logic signed [ppid_pkg::FIELD_W-1:0]   rsp_drive,
   input  logic                                  csr_we,
   input  logic        [ppid_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [ppid_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int OUT_W  = ppid_pkg::FIELD_W;
   localparam int EW     = VALUE_WIDTH;
   localparam int SUB_W  = (EW > OUT_W + 1) ? EW : OUT_W + 1;
   localparam int DIFF_W = EW + 1;
   localparam int IW     = ppid_pkg::INTEG_W;
   localparam int XW     = (EW > IW) ? EW : IW;
   localparam int MW     = ppid_pkg::DT_W;
   localparam int PW     = XW + MW;
   localparam int TF     = ppid_pkg::TIME_FRAC_W;
   localparam int GF     = ppid_pkg::GAIN_FRAC_W;
   localparam int NW     = DIFF_W + TF;
   localparam int QW     = ((NW > IW) ? NW : IW) + 1;
   localparam int STEP_W = PW - TF;
   localparam int ISUM_W = ((STEP_W > IW) ? STEP_W : IW) + 1;
   localparam int TW     = PW - GF;
   localparam int AW     = TW + 2;
   localparam int PGW    = ppid_pkg::PROP_W;
   localparam int IGW    = ppid_pkg::INTEG_GAIN_W;
   localparam int DGW    = ppid_pkg::DERIV_GAIN_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ERR_DT,
      S_DIFF,
      S_DIV,
      S_MUL_P,
      S_MUL_I,
      S_MUL_D,
      S_DONE
   } state_type;

   // Gain registers
   logic [PGW-1:0] prop_gain_ff;
   logic [IGW-1:0] integ_gain_ff;
   logic [DGW-1:0] deriv_gain_ff;
   logic [PGW-1:0] prop_wr, prop_cl;
   logic [IGW-1:0] integ_wr, integ_cl;
   logic [DGW-1:0] deriv_wr, deriv_cl;

   // Sequencer registers
   state_type              state_ff, state_in;
   logic                   start_ff, start_in;
   logic signed [EW-1:0]   err_ff, err_in;
   logic [MW-1:0]          dt_ff, dt_in;
   logic signed [EW-1:0]   last_err_ff, last_err_in;
   logic signed [IW-1:0]   integ_ff, integ_in;
   logic [DIFF_W-1:0]      mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic signed [IW-1:0]   deriv_ff, deriv_in;
   logic signed [AW-1:0]   drv_acc_ff, drv_acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_error_ff, rsp_error_in;
   logic signed [OUT_W-1:0] rsp_drive_ff, rsp_drive_in;

   // Datapath nets
   logic signed [SUB_W-1:0]  sub_wide;
   logic signed [EW-1:0]     err_sat;
   logic signed [DIFF_W-1:0] diff_w;
   logic                     diff_neg;
   logic [DIFF_W-1:0]        diff_mag;
   logic signed [STEP_W-1:0] integ_step;
   logic signed [ISUM_W-1:0] integ_sum;
   logic signed [IW-1:0]     integ_sat;
   logic signed [QW-1:0]     deriv_wide;
   logic signed [IW-1:0]     deriv_sat;
   logic signed [TW-1:0]     term;
   logic signed [EW-1:0]     drv_sat;

   // Unit connections
   logic                     mul_start, div_start;
   logic signed [XW-1:0]     mul_x;
   logic [MW-1:0]            mul_m;
   logic signed [PW-1:0]     mul_prod;
   logic [NW-1:0]            div_quo;
   ppid_pkg::unit_stat_type  mul_stat, div_stat;

   // Clamp gain writes into range
   always_comb begin
      prop_wr  = csr_wdata[PGW-1:0];
      integ_wr = csr_wdata[IGW-1:0];
      deriv_wr = csr_wdata[DGW-1:0];
      if (prop_wr < ppid_pkg::PROP_MIN) begin
         prop_cl = ppid_pkg::PROP_MIN;
      end else if (prop_wr > ppid_pkg::PROP_MAX) begin
         prop_cl = ppid_pkg::PROP_MAX;
      end else begin
         prop_cl = prop_wr;
      end
      integ_cl = (integ_wr > ppid_pkg::INTEG_MAX) ? ppid_pkg::INTEG_MAX : integ_wr;
      deriv_cl = (deriv_wr > ppid_pkg::DERIV_MAX) ? ppid_pkg::DERIV_MAX : deriv_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= ppid_pkg::PROP_RESET;
         integ_gain_ff <= ppid_pkg::INTEG_RESET;
         deriv_gain_ff <= ppid_pkg::DERIV_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ppid_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= prop_cl;
            ppid_pkg::CSR_INTEG_GAIN: integ_gain_ff <= integ_cl;
            ppid_pkg::CSR_DERIV_GAIN: deriv_gain_ff <= deriv_cl;
            default: ;
         endcase
      end
   end

   // Saturating error, integral, derivative and drive
   always_comb begin
      sub_wide = SUB_W'(req_target) - SUB_W'(req_measured);
      if ((&sub_wide[SUB_W-1:EW-1]) | ~(|sub_wide[SUB_W-1:EW-1])) begin
         err_sat = sub_wide[EW-1:0];
      end else begin
         err_sat = {sub_wide[SUB_W-1], {(EW-1){~sub_wide[SUB_W-1]}}};
      end

      diff_w   = DIFF_W'(err_ff) - DIFF_W'(last_err_ff);
      diff_neg = diff_w[DIFF_W-1];
      diff_mag = diff_neg ? (~diff_w + 1'b1) : diff_w;

      // error * dt floored to a whole number (Q56.0 at the default width), added with saturation
      integ_step = mul_prod[PW-1:TF];
      integ_sum  = ISUM_W'(integ_ff) + ISUM_W'(integ_step);
      if ((&integ_sum[ISUM_W-1:IW-1]) | ~(|integ_sum[ISUM_W-1:IW-1])) begin
         integ_sat = integ_sum[IW-1:0];
      end else begin
         integ_sat = {integ_sum[ISUM_W-1], {(IW-1){~integ_sum[ISUM_W-1]}}};
      end

      // restore the sign of the quotient, then saturate
      deriv_wide = neg_ff ? -QW'(div_quo) : QW'(div_quo);
      if ((&deriv_wide[QW-1:IW-1]) | ~(|deriv_wide[QW-1:IW-1])) begin
         deriv_sat = deriv_wide[IW-1:0];
      end else begin
         deriv_sat = {deriv_wide[QW-1], {(IW-1){~deriv_wide[QW-1]}}};
      end

      // gain product floored to a whole number (Q64.0 at the default width)
      term = mul_prod[PW-1:GF];

      if ((&drv_acc_ff[AW-1:EW-1]) | ~(|drv_acc_ff[AW-1:EW-1])) begin
         drv_sat = drv_acc_ff[EW-1:0];
      end else begin
         drv_sat = {drv_acc_ff[AW-1], {(EW-1){~drv_acc_ff[AW-1]}}};
      end
   end

   // Select the operands of the shared multiplier
   always_comb begin
      case (state_ff)
         S_MUL_P: begin
            mul_x = XW'(err_ff);
            mul_m = MW'(prop_gain_ff);
         end
         S_MUL_I: begin
            mul_x = XW'(integ_ff);
            mul_m = MW'(integ_gain_ff);
         end
         S_MUL_D: begin
            mul_x = XW'(deriv_ff);
            mul_m = MW'(deriv_gain_ff);
         end
         default: begin
            mul_x = XW'(err_ff);
            mul_m = dt_ff;
         end
      endcase
   end

   assign mul_start = start_ff && (state_ff != S_DIV);
   assign div_start = start_ff && (state_ff == S_DIV);

   // Sequencer: one product or quotient per arithmetic state
   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      err_in       = err_ff;
      dt_in        = dt_ff;
      last_err_in  = last_err_ff;
      integ_in     = integ_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      deriv_in     = deriv_ff;
      drv_acc_in   = drv_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_error_in = rsp_error_ff;
      rsp_drive_in = rsp_drive_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               err_in   = err_sat;
               dt_in    = req_time_step;
               state_in = S_ERR_DT;
               start_in = 1'b1;
            end
         end
         S_ERR_DT: begin
            if (mul_stat.done) begin
               integ_in = integ_sat;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            mag_in      = diff_mag;
            neg_in      = diff_neg;
            last_err_in = err_ff;
            start_in    = 1'b1;
            if (dt_ff >= ppid_pkg::DT_MIN_UNITS) begin
               state_in = S_DIV;
            end else begin
               deriv_in = '0;
               state_in = S_MUL_P;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               deriv_in = deriv_sat;
               state_in = S_MUL_P;
               start_in = 1'b1;
            end
         end
         S_MUL_P: begin
            if (mul_stat.done) begin
               drv_acc_in = AW'(term);
               state_in   = S_MUL_I;
               start_in   = 1'b1;
            end
         end
         S_MUL_I: begin
            if (mul_stat.done) begin
               drv_acc_in = drv_acc_ff + AW'(term);
               state_in   = S_MUL_D;
               start_in   = 1'b1;
            end
         end
         S_MUL_D: begin
            if (mul_stat.done) begin
               drv_acc_in = drv_acc_ff + AW'(term);
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_error_in = OUT_W'(err_ff);
               rsp_drive_in = OUT_W'(drv_sat);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      deriv_ff     <= deriv_in;
      drv_acc_ff   <= drv_acc_in;
      rsp_error_ff <= rsp_error_in;
      rsp_drive_ff <= rsp_drive_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   ppid_mul #(
      .XW (XW),
      .MW (MW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mul_x),
      .m     (mul_m),
      .stat  (mul_stat),
      .prod  (mul_prod)
   );

   ppid_div #(
      .NW (NW),
      .MW (MW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({mag_ff, {TF{1'b0}}}),
      .den   (dt_ff),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_error_value = rsp_error_ff;
   assign rsp_drive       = rsp_drive_ff;

`ifndef SYNTHESIS
   // The multiplier and divider never run at the same time
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   // An accepted word starts the error-times-step product
   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 mul_stat.busy)
      else $error("multiplier not started after accept");

   // Proportional gain stays inside its clamped range
   a_prop_range: assert property (@(posedge clock) disable iff (reset)
      (prop_gain_ff >= ppid_pkg::PROP_MIN) && (prop_gain_ff <= ppid_pkg::PROP_MAX))
      else $error("proportional gain out of range");

   // A finished word waits while the result register is occupied
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid && !rsp_ready) |=> (state_ff == S_DONE && rsp_valid))
      else $error("result overwritten while stalled");
`endif

endmodule
